// File: design/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// Used by every module of the block but pli_ram; depends on nothing.
package pli_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS   = 32;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_QUERY = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_FEW   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SRCH,
    BK_CMP,
    BK_RDA,
    BK_RDB,
    BK_MULA,
    BK_MULB,
    BK_SUM,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
  } out_word_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: design/pli_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/pli_queue.sv
// Short command queue between the front and the back of the interpolator.
// Depends on pli_pkg.
module pli_queue import pli_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/pli_front.sv
// Front end: takes an input word, decodes its function code into a command
// and hands it to the queue. Depends on pli_pkg.
module pli_front import pli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_word_t in_word,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     push_cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r;
  cmd_t dec_cmd;
  logic accept;

  always_comb begin
    dec_cmd.x = in_word.point_x;
    dec_cmd.y = in_word.point_y;
    unique case (in_word.func)
      FN_LOAD:  dec_cmd.op = OP_LOAD;
      FN_QUERY: dec_cmd.op = OP_QUERY;
      FN_CLEAR: dec_cmd.op = OP_CLEAR;
      default:  dec_cmd.op = OP_NOP;
    endcase
  end

  // The staged word waits only while the queue is full.
  assign busy     = valid_r && q_stat.full;
  assign accept   = start && !busy;
  assign push     = valid_r;
  assign push_cmd = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !q_stat.full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= dec_cmd;
    end
  end

endmodule

// File: design/pli_back.sv
// Back end: executes loads, clears and queries against the breakpoint tables.
// A query runs a binary search, two multiplies and a bit-serial divide.
// Depends on pli_pkg and pli_ram.
module pli_back import pli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  output out_word_t out_word
);

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [31:0] last_x_r;
  logic signed [31:0] qx_r;
  logic [CNT_W-1:0]   lo_r, hi_r, b_r;
  logic [CNT_W-1:0]   mid, b_sel, a_sel;
  logic signed [31:0] xa_r, ya_r, yb_r;
  logic signed [32:0] wa_r, wb_r;
  logic [31:0]        d_r;
  logic [63:0]        pa_r, pb_r;
  logic               sa_r, sb_r;
  logic [64:0]        m_r, m_sum;
  logic               neg_r, neg_sum, na, nb;
  logic               big_r;
  logic [31:0]        rem_r, q_r;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;
  out_word_t          out_r;
  logic [31:0]        sat_value;

  logic               wr_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [31:0]        x_rd, y_rd;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  assign pop = (state_r == BK_IDLE) && !q_stat.empty;
  assign wr_en = pop && (head.op == OP_LOAD) && (cnt_r < CNT_W'(MAX_POINTS))
                 && !((cnt_r != '0) && (head.x <= last_x_r));

  pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(cnt_r[IDX_W-1:0]), .wr_data(head.x),
    .rd_addr(rd_addr), .rd_data(x_rd)
  );

  pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(cnt_r[IDX_W-1:0]), .wr_data(head.y),
    .rd_addr(rd_addr), .rd_data(y_rd)
  );

  // Search midpoint and the segment chosen once the search has ended.
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  always_comb begin
    priority if (lo_r == '0) begin
      b_sel = CNT_W'(1);
    end else if (lo_r >= cnt_r) begin
      b_sel = cnt_r - 1'b1;
    end else begin
      b_sel = lo_r;
    end
    a_sel = b_sel - 1'b1;
  end

  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      BK_SRCH: rd_addr = (lo_r < hi_r) ? mid[IDX_W-1:0] : a_sel[IDX_W-1:0];
      BK_RDA:  rd_addr = b_r[IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  // Signed sum of the two products as sign and magnitude.
  always_comb begin
    na = sa_r && (pa_r != '0);
    nb = sb_r && (pb_r != '0);
    if (na == nb) begin
      m_sum   = {1'b0, pa_r} + {1'b0, pb_r};
      neg_sum = na;
    end else if (pa_r >= pb_r) begin
      m_sum   = {1'b0, pa_r - pb_r};
      neg_sum = na;
    end else begin
      m_sum   = {1'b0, pb_r - pa_r};
      neg_sum = nb;
    end
  end

  assign rem_sh = {rem_r, m_r[31]};
  assign rem_ge = (rem_sh >= {1'b0, d_r});

  always_comb begin
    if (!neg_r) begin
      sat_value = (big_r || q_r[31]) ? 32'h7FFF_FFFF : q_r;
    end else begin
      sat_value = (big_r || (q_r > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-q_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop && (head.op == OP_QUERY) && (cnt_r >= CNT_W'(2))) begin
          state_nxt = BK_SRCH;
        end
      end
      BK_SRCH: state_nxt = (lo_r < hi_r) ? BK_CMP : BK_RDA;
      BK_CMP:  state_nxt = BK_SRCH;
      BK_RDA:  state_nxt = BK_RDB;
      BK_RDB:  state_nxt = BK_MULA;
      BK_MULA: state_nxt = BK_MULB;
      BK_MULB: state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_DIV;
      BK_DIV:  state_nxt = (step_r == STEP_W'(DIV_STEPS - 1)) ? BK_DONE : BK_DIV;
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (pop) begin
        unique case (head.op)
          OP_LOAD: begin
            out_valid_r <= 1'b1;
            if (wr_en) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          OP_CLEAR: begin
            out_valid_r <= 1'b1;
            cnt_r       <= '0;
          end
          OP_QUERY: out_valid_r <= (cnt_r < CNT_W'(2));
          default:  out_valid_r <= 1'b1;
        endcase
      end
      if (state_r == BK_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        lo_r <= '0;
        hi_r <= cnt_r;
        qx_r <= head.x;
        if (wr_en) begin
          last_x_r <= head.x;
        end
        out_r.value  <= '0;
        out_r.status <= ST_OK;
        if (head.op == OP_LOAD) begin
          if (cnt_r >= CNT_W'(MAX_POINTS)) begin
            out_r.status <= ST_FULL;
          end else if (!wr_en) begin
            out_r.status <= ST_ORDER;
          end
        end else if ((head.op == OP_QUERY) && (cnt_r < CNT_W'(2))) begin
          out_r.status <= ST_FEW;
        end
      end
      BK_SRCH: b_r <= b_sel;
      BK_CMP: begin
        if ($signed(x_rd) < qx_r) begin
          lo_r <= mid + 1'b1;
        end else begin
          hi_r <= mid;
        end
      end
      BK_RDA: begin
        xa_r <= $signed(x_rd);
        ya_r <= $signed(y_rd);
      end
      BK_RDB: begin
        wa_r <= {x_rd[31], x_rd} - {qx_r[31], qx_r};
        wb_r <= {qx_r[31], qx_r} - {xa_r[31], xa_r};
        yb_r <= $signed(y_rd);
        d_r  <= x_rd - xa_r;
      end
      BK_MULA: begin
        pa_r <= 64'(mag33(wa_r) * mag32(ya_r));
        sa_r <= wa_r[32] ^ ya_r[31];
      end
      BK_MULB: begin
        pb_r <= 64'(mag33(wb_r) * mag32(yb_r));
        sb_r <= wb_r[32] ^ yb_r[31];
      end
      BK_SUM: begin
        // A high half at or above the divisor means the quotient needs more
        // than 32 bits, which saturates in any case.
        m_r    <= m_sum;
        neg_r  <= neg_sum;
        big_r  <= (m_sum[64:32] >= {1'b0, d_r});
        rem_r  <= m_sum[63:32];
        q_r    <= '0;
        step_r <= '0;
      end
      BK_DIV: begin
        rem_r  <= rem_ge ? 32'(rem_sh - {1'b0, d_r}) : rem_sh[31:0];
        q_r    <= {q_r[30:0], rem_ge};
        m_r    <= {m_r[63:0], 1'b0};
        step_r <= step_r + 1'b1;
      end
      BK_DONE: begin
        out_r.value  <= sat_value;
        out_r.status <= ST_OK;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// File: design/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: front end, command queue
// and execution back end. Depends on pli_pkg, pli_front, pli_queue, pli_back.

// Breakpoints are appended with load words (strictly ascending x), cleared
// with a clear word, and queried with query words; every word yields exactly
// one result, shown for a single cycle with out_valid, which the receiver
// must take then. Words go through a front stage and a two-entry queue, so
// start may be given while the back end is working; busy rises only when the
// queue is full and a further word already waits in the front stage.
// Loads, clears and rejected queries are handled in the back end's idle state.
// An accepted query holds the back end through the state that takes it,
// a memory read and a compare per step of the binary search over the table
// (at most seven steps for 64 points), a step that ends the search, two memory
// reads, two multiplies, a sum, a 32-step restoring divide (one quotient bit
// per cycle) and a saturation step; the result strobe follows in the next cycle.
module piecewise_linear_interpolator import pli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  q_stat_t q_stat;
  logic    push, pop;
  cmd_t    push_cmd, head;

  pli_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .q_stat(q_stat), .push(push), .push_cmd(push_cmd)
  );

  pli_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
    .head(head), .stat(q_stat)
  );

  pli_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .q_stat(q_stat), .pop(pop),
    .out_valid(out_valid), .out_word(out_word)
  );

`ifndef NO_ASSERTIONS
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ST_OK) |-> out_word.value == '0)
    else $error("rejected word carries a nonzero value");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("back end took a word from an empty queue");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for piecewise_linear_interpolator: random and directed
// load, query and clear words checked against a predictor of the breakpoint table.
// Depends on pli_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import pli_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  piecewise_linear_interpolator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Predictor state.
  logic signed [31:0] bp_x [MAX_POINTS];
  logic signed [31:0] bp_y [MAX_POINTS];
  int unsigned        bp_count = 0;

  in_word_t  pending_words [$];
  out_word_t expected_results [$];
  int        errors = 0;
  bit        calm;          // no idling in the last part of the run
  bit        hold_sender;   // sender waits for the block to drain
  int        gap_left;

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] interp(logic signed [31:0] qx);
    int unsigned lo, hi, mid, a, b;
    logic signed [63:0] xa, xb, ya, yb, wa, wb, xq;
    logic [63:0] pa, pb, m, d, q;
    bit na, nb, neg;
    lo = 0; hi = bp_count;
    xq = qx;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (bp_x[mid] < qx) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) begin
      a = 0; b = 1;
    end else if (lo >= bp_count) begin
      a = bp_count - 2; b = bp_count - 1;
    end else begin
      a = lo - 1; b = lo;
    end
    xa = bp_x[a]; xb = bp_x[b]; ya = bp_y[a]; yb = bp_y[b];
    wa = xb - xq; wb = xq - xa;
    pa = mag(wa) * mag(ya);
    pb = mag(wb) * mag(yb);
    na = ((wa < 0) != (ya < 0)) && pa != 0;
    nb = ((wb < 0) != (yb < 0)) && pb != 0;
    if (na == nb) begin
      m = pa + pb; neg = na;
    end else if (pa >= pb) begin
      m = pa - pb; neg = na;
    end else begin
      m = pb - pa; neg = nb;
    end
    d = xb - xa;
    q = d != 0 ? m / d : 0;
    if (!neg) return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return -q[31:0];
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    r.value  = '0;
    r.status = ST_OK;
    case (w.func)
      FN_LOAD: begin
        if (bp_count >= MAX_POINTS) r.status = ST_FULL;
        else if (bp_count > 0 && w.point_x <= bp_x[bp_count-1]) r.status = ST_ORDER;
        else begin
          bp_x[bp_count] = w.point_x;
          bp_y[bp_count] = w.point_y;
          bp_count++;
        end
      end
      FN_QUERY: begin
        if (bp_count < 2) r.status = ST_FEW;
        else r.value = interp(w.point_x);
      end
      FN_CLEAR: bp_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  // Driver: one word offered at a time, random gaps between words.
  // An accepted word leaves the pending queue at once, so the next one is
  // always at the front.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_word <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), predict_result(in_word));
        void'(pending_words.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (hold_sender || pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 10);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_word <= pending_words[0];
      end
    end
  end

  // Monitor: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 out_word.value, out_word.status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_word.value !== e.value) begin
          $display("%0t: value expected %h actual %h", $time, e.value, out_word.value);
          errors++;
        end
        if (out_word.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status,
                   out_word.status);
          errors++;
        end
      end
    end
  end

  // Model of the table the stimulus builds, to aim queries and loads.
  logic signed [31:0] gen_last_x;
  int unsigned        gen_count;

  task automatic add_word(func_t f, logic [31:0] x, logic [31:0] y);
    in_word_t w;
    w.func = f; w.point_x = x; w.point_y = y;
    pending_words.insert(pending_words.size(), w);
    if (f == FN_CLEAR) gen_count = 0;
    if (f == FN_LOAD && gen_count < MAX_POINTS &&
        (gen_count == 0 || $signed(x) > gen_last_x)) begin
      gen_count++;
      gen_last_x = x;
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int n, pts;
    logic signed [63:0] xs;
    logic [31:0] step;
    calm = 0; hold_sender = 0;
    gen_count = 0; gen_last_x = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: corner values, each function, each rejection.
    add_word(FN_QUERY, 32'd5, 32'd0);
    add_word(FN_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
    add_word(FN_QUERY, 32'd0, 32'd0);
    add_word(FN_LOAD, 32'h8000_0000, 32'd1);
    add_word(FN_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    add_word(FN_QUERY, 32'h8000_0000, 32'hFFFF_FFFF);
    add_word(FN_QUERY, 32'h7FFF_FFFF, 32'h0);
    add_word(FN_QUERY, 32'h0, 32'h0);
    add_word(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(FN_CLEAR, 32'h0, 32'h0);
    add_word(FN_LOAD, 32'd0, 32'h7FFF_FFFF);
    add_word(FN_LOAD, 32'd1, 32'h8000_0000);
    add_word(FN_LOAD, 32'd1, 32'd0);
    add_word(FN_QUERY, 32'h8000_0000, 32'd0);
    add_word(FN_QUERY, 32'h7FFF_FFFF, 32'd0);
    add_word(FN_QUERY, 32'd1, 32'd0);
    add_word(FN_QUERY, 32'd0, 32'd0);
    // Fill the table to the top, then overflow it.
    add_word(FN_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < MAX_POINTS; i++)
      add_word(FN_LOAD, 32'h8000_0000 + i * 32'h0400_0000 + i, rand_word());
    add_word(FN_LOAD, 32'h7FFF_FFFF, 32'd3);
    add_word(FN_QUERY, 32'h7FFF_FFFF, 32'd0);
    add_word(FN_QUERY, 32'h0400_0005, 32'd0);

    // Pause until the block has answered everything so far.
    wait (pending_words.size() == 0 && !start);
    hold_sender = 1;
    while (expected_results.size() != 0) @(posedge clk);
    hold_sender = 0;

    // Random part: mostly ascending table builds followed by queries.
    n = 0;
    while (n < 1750) begin
      if (n > 1500) calm = 1;
      add_word(FN_CLEAR, rand_word(), rand_word());
      n++;
      pts = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_POINTS + 2)
                                        : $urandom_range(0, 8);
      xs = $signed(rand_word()) >>> $urandom_range(0, 31);
      step = 32'd1 << $urandom_range(0, 27);
      for (int i = 0; i < pts; i++) begin
        if ($urandom_range(0, 15) == 0) add_word(FN_LOAD, rand_word(), rand_word());
        else begin
          xs = xs + $urandom_range(1, step);
          if (xs > 64'sh7FFF_FFFF) xs = 64'sh7FFF_FFFF;
          add_word(FN_LOAD, xs[31:0], rand_word());
        end
        n++;
      end
      for (int i = $urandom_range(1, 10); i > 0; i--) begin
        case ($urandom_range(0, 9))
          0: add_word(FN_NONE, rand_word(), rand_word());
          1: add_word(FN_QUERY, gen_last_x, rand_word());
          2: add_word(FN_QUERY, rand_word(), rand_word());
          default: add_word(FN_QUERY, xs[31:0] - $urandom_range(0, step * pts),
                            rand_word());
        endcase
        n++;
      end
      while (pending_words.size() > 50) @(posedge clk);
    end

    wait_drained();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
